// ----- sv/wavhp_pkg.sv -----
// Package: shared types, tags and codes for the WAV header parser.
`timescale 1ns / 1ps
package wavhp_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [31:0] FMT_BASE_LEN = 32'd16;
	localparam logic [15:0] MAX_CHANNELS = 16'd2;
	localparam logic [15:0] PCM_FORMAT   = 16'd1;

	// byte offsets within the fixed header that complete a field
	localparam logic [5:0] OFF_RIFF     = 6'd3;
	localparam logic [5:0] OFF_WAVE     = 6'd11;
	localparam logic [5:0] OFF_FMT      = 6'd15;
	localparam logic [5:0] OFF_FMT_LEN  = 6'd19;
	localparam logic [5:0] OFF_FORMAT   = 6'd21;
	localparam logic [5:0] OFF_CHANNELS = 6'd23;
	localparam logic [5:0] OFF_RATE     = 6'd27;
	localparam logic [5:0] OFF_BYTERATE = 6'd31;
	localparam logic [5:0] OFF_ALIGN    = 6'd33;
	localparam logic [5:0] OFF_BITS     = 6'd35;

	localparam logic [31:0] TAIL_TAG_END  = 32'd3;
	localparam logic [31:0] TAIL_SIZE_END = 32'd7;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_SKIP,
		PH_TAIL,
		PH_PAYLOAD,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		ST_BUSY         = 3'd0,
		ST_OK           = 3'd1,
		ST_NOT_RIFF     = 3'd2,
		ST_NOT_WAVE     = 3'd3,
		ST_NOT_FMT      = 3'd4,
		ST_NOT_PCM      = 3'd5,
		ST_BAD_CHANNELS = 3'd6,
		ST_NOT_DATA     = 3'd7
	} status_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       start_of_file;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

	typedef struct packed {
		status_t     status;
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic        payload_last;
		logic [1:0]  channels;
		logic [31:0] rate;
		logic [31:0] bytes_per_second;
		logic [15:0] frame_bytes;
		logic [15:0] sample_bits;
		logic [31:0] payload_length;
	} result_t;

endpackage

// ----- sv/wavhp_in_if.sv -----
// Interface: byte channel into the parser.
`timescale 1ns / 1ps
interface wavhp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       start_of_file;

	modport source (output valid, output in_byte, output start_of_file, input ready);
	modport sink   (input valid, input in_byte, input start_of_file, output ready);
endinterface

// ----- sv/wavhp_out_if.sv -----
// Interface: result channel out of the parser.
`timescale 1ns / 1ps
interface wavhp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic        payload_last;
	logic [1:0]  channels;
	logic [31:0] rate;
	logic [31:0] bytes_per_second;
	logic [15:0] frame_bytes;
	logic [15:0] sample_bits;
	logic [31:0] payload_length;

	modport source (
		output valid, output status, output payload_valid, output payload_byte,
		output payload_last, output channels, output rate, output bytes_per_second,
		output frame_bytes, output sample_bits, output payload_length, input ready
	);
	modport sink (
		input valid, input status, input payload_valid, input payload_byte,
		input payload_last, input channels, input rate, input bytes_per_second,
		input frame_bytes, input sample_bits, input payload_length, output ready
	);
endinterface

// ----- sv/wavhp_front.sv -----
// Front end: accepts bytes and holds them in a short queue for the parser.
`timescale 1ns / 1ps
module wavhp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	wavhp_in_if.sink             byte_ch,
	output wavhp_pkg::queue_head_t head,
	input  logic                 pop
);

	wavhp_pkg::item_t                  slot_q [wavhp_pkg::QUEUE_DEPTH];
	logic [wavhp_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [wavhp_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [wavhp_pkg::QCNT_W-1:0]      count_q;
	logic                              push;
	logic                              do_pop;

	assign byte_ch.ready = (count_q != wavhp_pkg::QCNT_W'(wavhp_pkg::QUEUE_DEPTH));
	assign push          = byte_ch.valid && byte_ch.ready;
	assign do_pop        = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{in_byte: byte_ch.in_byte, start_of_file: byte_ch.start_of_file};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == wavhp_pkg::QPTR_W'(wavhp_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == wavhp_pkg::QPTR_W'(wavhp_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= wavhp_pkg::QCNT_W'(wavhp_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

// ----- sv/wavhp_core.sv -----
// Back end: header parse state machine, captured fields and result register.
`timescale 1ns / 1ps
module wavhp_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wavhp_pkg::queue_head_t head,
	output logic                   pop,
	wavhp_out_if.source            result_ch
);

	wavhp_pkg::phase_t  phase_q, phase_n;
	wavhp_pkg::status_t err_q, err_n;
	logic [31:0] fcount_q, fcount_n;
	logic [31:0] asm_q, asm_n;
	logic [31:0] extra_q, extra_n;
	logic [1:0]  chan_q, chan_n;
	logic [31:0] rate_q, rate_n;
	logic [31:0] brate_q, brate_n;
	logic [15:0] align_q, align_n;
	logic [15:0] bits_q, bits_n;
	logic [31:0] dsize_q, dsize_n;
	logic [15:0] half;
	logic        pv, pl;
	wavhp_pkg::status_t status_n;

	wavhp_pkg::result_t res_q;
	logic               res_valid_q;

	assign pop = head.valid && (!res_valid_q || result_ch.ready);

	always_comb begin
		phase_n  = phase_q;
		err_n    = err_q;
		fcount_n = fcount_q;
		asm_n    = asm_q;
		extra_n  = extra_q;
		chan_n   = chan_q;
		rate_n   = rate_q;
		brate_n  = brate_q;
		align_n  = align_q;
		bits_n   = bits_q;
		dsize_n  = dsize_q;
		pv       = 1'b0;
		pl       = 1'b0;

		if (head.item.start_of_file) begin
			phase_n  = wavhp_pkg::PH_HEADER;
			err_n    = wavhp_pkg::ST_BUSY;
			fcount_n = '0;
			asm_n    = '0;
			extra_n  = '0;
			chan_n   = '0;
			rate_n   = '0;
			brate_n  = '0;
			align_n  = '0;
			bits_n   = '0;
			dsize_n  = '0;
		end
		if (phase_n == wavhp_pkg::PH_HEADER || phase_n == wavhp_pkg::PH_TAIL) begin
			asm_n = {head.item.in_byte, asm_n[31:8]};
		end
		half = asm_n[31:16];

		unique case (phase_n)
			wavhp_pkg::PH_HEADER: begin
				fcount_n = fcount_n + 32'd1;
				unique case (fcount_n[5:0] - 6'd1)
					wavhp_pkg::OFF_RIFF: if (asm_n != wavhp_pkg::TAG_RIFF) begin
						err_n   = wavhp_pkg::ST_NOT_RIFF;
						phase_n = wavhp_pkg::PH_DONE;
					end
					wavhp_pkg::OFF_WAVE: if (asm_n != wavhp_pkg::TAG_WAVE) begin
						err_n   = wavhp_pkg::ST_NOT_WAVE;
						phase_n = wavhp_pkg::PH_DONE;
					end
					wavhp_pkg::OFF_FMT: if (asm_n != wavhp_pkg::TAG_FMT) begin
						err_n   = wavhp_pkg::ST_NOT_FMT;
						phase_n = wavhp_pkg::PH_DONE;
					end
					wavhp_pkg::OFF_FMT_LEN: begin
						extra_n = (asm_n > wavhp_pkg::FMT_BASE_LEN) ?
							asm_n - wavhp_pkg::FMT_BASE_LEN : '0;
					end
					wavhp_pkg::OFF_FORMAT: if (half != wavhp_pkg::PCM_FORMAT) begin
						err_n   = wavhp_pkg::ST_NOT_PCM;
						phase_n = wavhp_pkg::PH_DONE;
					end
					wavhp_pkg::OFF_CHANNELS: begin
						if (half == '0 || half > wavhp_pkg::MAX_CHANNELS) begin
							err_n   = wavhp_pkg::ST_BAD_CHANNELS;
							phase_n = wavhp_pkg::PH_DONE;
						end else begin
							chan_n = half[1:0];
						end
					end
					wavhp_pkg::OFF_RATE:     rate_n  = asm_n;
					wavhp_pkg::OFF_BYTERATE: brate_n = asm_n;
					wavhp_pkg::OFF_ALIGN:    align_n = half;
					wavhp_pkg::OFF_BITS: begin
						bits_n   = half;
						fcount_n = '0;
						phase_n  = (extra_n != '0) ? wavhp_pkg::PH_SKIP : wavhp_pkg::PH_TAIL;
					end
					default: ;
				endcase
			end
			wavhp_pkg::PH_SKIP: begin
				extra_n = extra_n - 32'd1;
				if (extra_n == '0) begin
					fcount_n = '0;
					phase_n  = wavhp_pkg::PH_TAIL;
				end
			end
			wavhp_pkg::PH_TAIL: begin
				if (fcount_n == wavhp_pkg::TAIL_TAG_END && asm_n != wavhp_pkg::TAG_DATA) begin
					err_n   = wavhp_pkg::ST_NOT_DATA;
					phase_n = wavhp_pkg::PH_DONE;
				end else if (fcount_n == wavhp_pkg::TAIL_SIZE_END) begin
					dsize_n  = asm_n;
					fcount_n = asm_n;
					phase_n  = (asm_n != '0) ? wavhp_pkg::PH_PAYLOAD : wavhp_pkg::PH_DONE;
				end else begin
					fcount_n = fcount_n + 32'd1;
				end
			end
			wavhp_pkg::PH_PAYLOAD: begin
				pv       = 1'b1;
				fcount_n = fcount_n - 32'd1;
				if (fcount_n == '0) begin
					pl      = 1'b1;
					phase_n = wavhp_pkg::PH_DONE;
				end
			end
			default: ;
		endcase

		if (err_n != wavhp_pkg::ST_BUSY) begin
			status_n = err_n;
		end else if (phase_n == wavhp_pkg::PH_PAYLOAD || phase_n == wavhp_pkg::PH_DONE) begin
			status_n = wavhp_pkg::ST_OK;
		end else begin
			status_n = wavhp_pkg::ST_BUSY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= wavhp_pkg::PH_IDLE;
			err_q       <= wavhp_pkg::ST_BUSY;
			fcount_q    <= '0;
			asm_q       <= '0;
			extra_q     <= '0;
			chan_q      <= '0;
			rate_q      <= '0;
			brate_q     <= '0;
			align_q     <= '0;
			bits_q      <= '0;
			dsize_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_n;
				err_q       <= err_n;
				fcount_q    <= fcount_n;
				asm_q       <= asm_n;
				extra_q     <= extra_n;
				chan_q      <= chan_n;
				rate_q      <= rate_n;
				brate_q     <= brate_n;
				align_q     <= align_n;
				bits_q      <= bits_n;
				dsize_q     <= dsize_n;
				res_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.status           <= status_n;
			res_q.payload_valid    <= pv;
			res_q.payload_byte     <= pv ? head.item.in_byte : 8'd0;
			res_q.payload_last     <= pl;
			res_q.channels         <= chan_n;
			res_q.rate             <= rate_n;
			res_q.bytes_per_second <= brate_n;
			res_q.frame_bytes      <= align_n;
			res_q.sample_bits      <= bits_n;
			res_q.payload_length   <= dsize_n;
		end
	end

	assign result_ch.valid            = res_valid_q;
	assign result_ch.status           = res_q.status;
	assign result_ch.payload_valid    = res_q.payload_valid;
	assign result_ch.payload_byte     = res_q.payload_byte;
	assign result_ch.payload_last     = res_q.payload_last;
	assign result_ch.channels         = res_q.channels;
	assign result_ch.rate             = res_q.rate;
	assign result_ch.bytes_per_second = res_q.bytes_per_second;
	assign result_ch.frame_bytes      = res_q.frame_bytes;
	assign result_ch.sample_bits      = res_q.sample_bits;
	assign result_ch.payload_length   = res_q.payload_length;

`ifndef SYNTH
	a_last_is_payload: assert property (@(posedge clk) disable iff (!arst_n)
		pop && pl |=> phase_q == wavhp_pkg::PH_DONE && res_q.payload_valid)
		else $error("last payload byte did not close the file");
	a_err_held: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != wavhp_pkg::ST_BUSY && !(pop && head.item.start_of_file)
		|=> err_q == $past(err_q))
		else $error("latched error changed without a new file");
	a_err_done: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != wavhp_pkg::ST_BUSY |-> phase_q == wavhp_pkg::PH_DONE)
		else $error("error latched while still parsing");
`endif

endmodule

// ----- sv/wav_header_parser.sv -----
// Top level: WAV (RIFF, PCM) header parser with payload byte forwarding.
//
//  channel    | role   | transfer carries
//  byte_ch    | sink   | in_byte, start_of_file
//  result_ch  | source | status, payload flags and byte, captured header fields
//
//  One result per byte; one byte per cycle unless result_ch stalls; bytes pass a
//  queue slot, then result register. The parse state machine in the back end
//  is the single per-byte step. A two-entry queue parts the byte side from the
//  parser and the result register parts the parser from the result side, so
//  either may stall alone. Reset clears all parser state; no warm-up is needed.
`timescale 1ns / 1ps
module wav_header_parser (
	input  logic         clk,
	input  logic         arst_n,
	wavhp_in_if.sink     byte_ch,
	wavhp_out_if.source  result_ch
);

	wavhp_pkg::queue_head_t head;
	logic                   pop;

	wavhp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.head    (head),
		.pop     (pop)
	);

	wavhp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.result_ch (result_ch)
	);

endmodule
